/* rtl/dmlps_pkg.sv */
// Shared types and constants of the debounced mode LED pattern sequencer.
`default_nettype none

package dmlps_pkg;

   typedef enum logic [1:0] {
      MODE_FOUR  = 2'd0,
      MODE_FIVE  = 2'd1,
      MODE_RUN   = 2'd2,
      MODE_CHECK = 2'd3
   } mode_type;

   // Register indexes of the configuration port.
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_INTERVAL = 1'b1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] INTERVAL_RESET = 16'd3000;

   localparam logic [7:0] LEDS_FOUR  = 8'h0F;
   localparam logic [7:0] LEDS_FIVE  = 8'h1F;
   localparam logic [7:0] CHECK_EVEN = 8'h55;
   localparam logic [7:0] CHECK_ODD  = 8'hAA;

   // Narrow control state that does not depend on the time width.
   typedef struct packed {
      logic       stable_level;
      mode_type   mode;
      logic [2:0] step;
      logic [7:0] leds;
   } ctl_type;

   // One result beat, declared from the highest bit down, in the same layout as on the port.
   typedef struct packed {
      logic [1:0] mode_now;
      logic       bounce_seen;
      logic       pattern_written;
      logic [7:0] led_pattern;
   } result_type;

endpackage

`default_nettype wire

/* rtl/dmlps_step.sv */
// Next-state and result logic for one button poll.
`default_nettype none

module dmlps_step #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic                  level,
   input  wire logic [TIME_WIDTH-1:0] now,
   input  wire logic [15:0]           debounce_ms,
   input  wire logic [15:0]           interval_ms,
   input  wire dmlps_pkg::ctl_type    ctl,
   input  wire logic [TIME_WIDTH-1:0] last_accept,
   input  wire logic [TIME_WIDTH-1:0] last_step,
   output dmlps_pkg::ctl_type         ctl_next,
   output logic [TIME_WIDTH-1:0]      last_accept_next,
   output logic [TIME_WIDTH-1:0]      last_step_next,
   output dmlps_pkg::result_type      result
);
   import dmlps_pkg::*;

   logic [TIME_WIDTH-1:0] since_accept;
   logic [TIME_WIDTH-1:0] since_step;
   logic                  change;
   logic                  accept;
   logic                  tick;
   ctl_type               ctl_press;
   logic                  written_press;
   logic                  written;

   assign since_accept = now - last_accept;
   assign since_step   = now - last_step;
   assign change       = level != ctl.stable_level;
   assign accept       = change && (since_accept > TIME_WIDTH'(debounce_ms));
   assign tick         = since_step >= TIME_WIDTH'(interval_ms);

   // The press is handled first; the interval test then sees the new mode.
   always_comb begin
      ctl_press     = ctl;
      written_press = 1'b0;
      if (accept) begin
         ctl_press.stable_level = level;
         if (!level) begin
            ctl_press.mode = mode_type'(2'(ctl.mode + 2'd1));
            case (ctl_press.mode)
               MODE_FOUR: begin
                  ctl_press.leds = LEDS_FOUR;
                  written_press  = 1'b1;
               end
               MODE_FIVE: begin
                  ctl_press.leds = LEDS_FIVE;
                  written_press  = 1'b1;
               end
               default: begin
                  ctl_press.step = 3'd0;
               end
            endcase
         end
      end
   end

   always_comb begin
      ctl_next = ctl_press;
      written  = written_press;
      if (tick) begin
         case (ctl_press.mode)
            MODE_RUN: begin
               ctl_next.leds = 8'd1 << ctl_press.step;
               ctl_next.step = 3'(ctl_press.step + 3'd1);
               written       = 1'b1;
            end
            MODE_CHECK: begin
               ctl_next.leds = ctl_press.step[0] ? CHECK_ODD : CHECK_EVEN;
               ctl_next.step = 3'(ctl_press.step + 3'd1);
               written       = 1'b1;
            end
            default: begin
               ctl_next.leds = ctl_press.leds;
            end
         endcase
      end
   end

   assign last_accept_next = accept ? now : last_accept;
   assign last_step_next   = tick ? now : last_step;

   assign result.mode_now        = ctl_next.mode;
   assign result.bounce_seen     = change && !accept;
   assign result.pattern_written = written;
   assign result.led_pattern     = ctl_next.leds;

endmodule

`default_nettype wire

/* rtl/debounced_mode_led_pattern_sequencer.sv */
// Top level of the debounced mode LED pattern sequencer.
`default_nettype none

// Each request beat is one poll of a push button: the sampled pin level
// (0 pressed, 1 released) and a free-running millisecond time. A level change
// is taken only when strictly more than debounce_ms have passed since the last
// taken change; otherwise the poll reports a bounce. Every taken press steps
// the mode 0, 1, 2, 3 and around: mode 0 lights four LEDs, mode 1 lights five,
// mode 2 runs a single LED and mode 3 alternates 0x55 and 0xAA, the last two
// advancing once every interval_ms. Every poll gives exactly one
// response beat with the LEDs, a written flag, the bounce flag and the mode.
// The block takes one poll every clock cycle while it is not stalled. A poll
// is held in the input register, where the debounce and interval logic
// updates the state, and leaves through the output register. Back-pressure
// on the response side stalls the request side only when both registers are
// full. Time differences wrap modulo 2**TIME_WIDTH. The two interval
// registers may be written only while no poll is in flight.

module debounced_mode_led_pattern_sequencer #(
   parameter int TIME_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // button_level [0], now_ms [32:1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // led_pattern [7:0], pattern_written [8],
                                         // bounce_seen [9], mode_now [11:10]
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import dmlps_pkg::*;

   localparam ctl_type CTL_RESET = '{
      stable_level: 1'b1,
      mode:         MODE_FOUR,
      step:         3'd0,
      leds:         LEDS_FOUR
   };

   // Configuration registers.
   logic [15:0] debounce_ff;
   logic [15:0] interval_ff;

   // Input register.
   logic        in_valid_ff;
   logic        level_ff;
   logic [31:0] now_ff;

   // Poll state.
   ctl_type               ctl_ff;
   ctl_type               ctl_in;
   logic [TIME_WIDTH-1:0] last_accept_ff;
   logic [TIME_WIDTH-1:0] last_accept_in;
   logic [TIME_WIDTH-1:0] last_step_ff;
   logic [TIME_WIDTH-1:0] last_step_in;

   // Output register.
   logic       out_valid_ff;
   result_type result_ff;
   result_type result_in;

   logic out_load;
   logic in_load;

   // The output register loads whenever it is empty or being drained; the
   // input register refills in the same cycle it hands its poll on.
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   dmlps_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .level            (level_ff),
      .now              (TIME_WIDTH'(now_ff)),
      .debounce_ms      (debounce_ff),
      .interval_ms      (interval_ff),
      .ctl              (ctl_ff),
      .last_accept      (last_accept_ff),
      .last_step        (last_step_ff),
      .ctl_next         (ctl_in),
      .last_accept_next (last_accept_in),
      .last_step_next   (last_step_in),
      .result           (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata;
            CSR_INTERVAL: interval_ff <= csr_wdata;
            default: begin
               debounce_ff <= debounce_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         level_ff <= req_tdata[0];
         now_ff   <= req_tdata[32:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff         <= CTL_RESET;
         last_accept_ff <= '0;
         last_step_ff   <= '0;
      end else if (out_load) begin
         ctl_ff         <= ctl_in;
         last_accept_ff <= last_accept_in;
         last_step_ff   <= last_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, result_ff};

   // The poll state moves only when a poll is handed to the output register.
   assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(ctl_ff))
      else $error("poll state changed without a poll");

   // A mode advances by at most one step per poll.
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (ctl_ff.mode == $past(ctl_ff.mode)) ||
                   (ctl_ff.mode == mode_type'(2'($past(ctl_ff.mode) + 2'd1))))
      else $error("mode skipped a step");

   // A rejected bounce never changes the mode.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && result_in.bounce_seen) |-> (ctl_in.mode == ctl_ff.mode))
      else $error("bounce changed the mode");

   // A write in mode 0 always shows four LEDs.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.pattern_written && result_ff.mode_now == MODE_FOUR)
      |-> (result_ff.led_pattern == LEDS_FOUR))
      else $error("wrong pattern written in mode 0");

   // A write in the running mode lights exactly one LED.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.pattern_written && result_ff.mode_now == MODE_RUN)
      |-> $onehot(result_ff.led_pattern))
      else $error("running pattern is not a single LED");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench of the debounced mode LED pattern sequencer.
`timescale 1ns / 100ps

module tb;
   import dmlps_pkg::*;

   // One row of the directed script. A settings row writes both interval
   // registers once the block has gone idle; any other row is one poll. The
   // display of a pinned row is written out by hand, every other row is
   // predicted.
   typedef struct packed {
      logic        settings;
      logic [15:0] lockout;
      logic [15:0] period;
      logic        level;
      logic [31:0] now_ms;
      logic        pinned;
      result_type  want;
   } script_row;

   // Display fixed by hand for one poll, in the order in which polls are sent.
   typedef struct packed {
      logic       pinned;
      result_type want;
   } pin_entry;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // button_level [0], now_ms [32:1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // led_pattern [7:0], pattern_written [8],
                                  // bounce_seen [9], mode_now [11:10]
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_DEBOUNCE;
   logic [15:0] csr_wdata = '0;

   // Predicted state of the sequencer and its two interval registers.
   logic        held_level;
   logic [31:0] accept_ms;
   mode_type    mode;
   logic [2:0]  step;
   logic [31:0] step_ms;
   logic [7:0]  leds;
   logic [15:0] lockout_ms;
   logic [15:0] period_ms;

   result_type  display_q[$];
   pin_entry    pinned_q[$];
   int          polls_sent = 0;
   int          displays_seen = 0;
   int          mismatches = 0;
   int          burst_left = 0;
   logic [8:0]  stall_tick = '0;

   // Directed polls. The first part runs with the reset intervals (50 ms
   // lockout, 3000 ms period); the pinned displays are in the field order
   // mode_now, bounce_seen, pattern_written, led_pattern.
   script_row script [0:26] = '{
      // Released and idle right after reset: four LEDs, nothing happens.
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'd0, 1'b1, '{MODE_FOUR, 1'b0, 1'b0, LEDS_FOUR}},
      // A press exactly at the lockout edge is still a bounce.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd50, 1'b1, '{MODE_FOUR, 1'b1, 1'b0, LEDS_FOUR}},
      // One millisecond later the press is taken: five LEDs.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd51, 1'b1, '{MODE_FIVE, 1'b0, 1'b1, LEDS_FIVE}},
      // Early release is a bounce.
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'd60, 1'b1, '{MODE_FIVE, 1'b1, 1'b0, LEDS_FIVE}},
      // Release taken: only the level and the accept time move.
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'd102, 1'b0, '0},
      // Press into the running mode together with the first interval.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd3000, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd5999, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd6000, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'd6001, 1'b0, '0},
      // Press into the checker mode, then an even and an odd step.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd6100, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd9100, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd12100, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'd12200, 1'b0, '0},
      // The mode wraps from checker back to four LEDs.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'd12300, 1'b1, '{MODE_FOUR, 1'b0, 1'b1, LEDS_FOUR}},
      // Interval in mode 0 near the top of the time range: timer only.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'hFFFF_FFF0, 1'b0, '0},
      // Release across the time wrap.
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'h0000_0010, 1'b0, '0},
      // A difference of 32 ms after the wrap is inside the lockout.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'h0000_0030, 1'b1, '{MODE_FOUR, 1'b1, 1'b0, LEDS_FOUR}},
      // Zero lockout and zero period.
      '{1'b1, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0, '0},
      // Time has not moved, so even a zero lockout rejects the change.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'h0000_0010, 1'b1, '{MODE_FOUR, 1'b1, 1'b0, LEDS_FOUR}},
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'h0000_0031, 1'b1, '{MODE_FIVE, 1'b0, 1'b1, LEDS_FIVE}},
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'h0000_0032, 1'b0, '0},
      // Running mode with a zero period steps on every poll.
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'h0000_0033, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b0, 32'h0000_0033, 1'b0, '0},
      // Largest lockout and period.
      '{1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'h0000_0034, 1'b0, '0},
      // Exactly 65535 ms: a bounce, but a pattern step.
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'h0001_0032, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 1'b1, 32'h0001_0033, 1'b0, '0}
   };

   debounced_mode_led_pattern_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the display after one poll and moves the predicted state on.
   // The button is handled first, then the pattern interval, which sees the new
   // mode; the two never both write in the same poll.
   function automatic result_type next_display(input logic level, input logic [31:0] now_ms);
      result_type  r;
      logic [31:0] since;
      r = '0;
      if (level != held_level) begin
         since = now_ms - accept_ms;
         if (since > 32'(lockout_ms)) begin
            held_level = level;
            accept_ms  = now_ms;
            // Only a press moves the mode; a taken release changes nothing else.
            if (!level) begin
               mode = mode_type'(mode + 2'd1);
               case (mode)
                  MODE_FOUR: begin
                     leds = LEDS_FOUR;
                     r.pattern_written = 1'b1;
                  end
                  MODE_FIVE: begin
                     leds = LEDS_FIVE;
                     r.pattern_written = 1'b1;
                  end
                  default: step = '0;
               endcase
            end
         end else begin
            r.bounce_seen = 1'b1;
         end
      end
      since = now_ms - step_ms;
      if (since >= 32'(period_ms)) begin
         // The timer restarts in every mode, but only the two animated
         // modes change the LEDs and the step.
         step_ms = now_ms;
         if (mode == MODE_RUN || mode == MODE_CHECK) begin
            if (mode == MODE_RUN) begin
               leds = 8'd1 << step;
            end else begin
               leds = step[0] ? CHECK_ODD : CHECK_EVEN;
            end
            step = step + 3'd1;
            r.pattern_written = 1'b1;
         end
      end
      r.led_pattern = leds;
      r.mode_now    = mode;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Predictor and scoreboard in one process, so that a poll is always
   // predicted before any later response is compared. Register writes are
   // mirrored here as the block sees them.
   always @(posedge clock) begin
      pin_entry   pin;
      result_type want;
      result_type got;
      result_type guess;
      if (reset) begin
         held_level = 1'b1;
         accept_ms  = '0;
         mode       = MODE_FOUR;
         step       = '0;
         step_ms    = '0;
         leds       = LEDS_FOUR;
         lockout_ms = DEBOUNCE_RESET;
         period_ms  = INTERVAL_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE: lockout_ms = csr_wdata;
               CSR_INTERVAL: period_ms  = csr_wdata;
               default:      lockout_ms = lockout_ms;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pin   = pinned_q.pop_front();
            guess = next_display(req_tdata[0], req_tdata[32:1]);
            display_q.push_back(pin.pinned ? pin.want : guess);
         end
         if (rsp_tvalid && rsp_tready) begin
            displays_seen++;
            if (display_q.size() == 0) begin
               $error("response beat with no poll waiting: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = display_q.pop_front();
               got  = result_type'(rsp_tdata[11:0]);
               check_field("led_pattern", want.led_pattern, got.led_pattern);
               check_field("pattern_written", 8'(want.pattern_written),
                           8'(got.pattern_written));
               check_field("bounce_seen", 8'(want.bounce_seen), 8'(got.bounce_seen));
               check_field("mode_now", 8'(want.mode_now), 8'(got.mode_now));
            end
         end
      end
   end

   // The response side takes turns between four stall patterns: always ready,
   // coin flips, a stall whenever the two low counter bits are zero, and on/off blocks that follow counter bit 2.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 9'd1;
      case (stall_tick[8:7])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= (stall_tick[1:0] != 2'd0);
         default: rsp_tready <= stall_tick[2];
      endcase
   end

   // Sends one poll beat. Polls go out in bursts of random length; between
   // bursts the valid usually drops for a random gap, though some bursts
   // run straight into each other.
   task automatic send_poll(input logic level, input logic [31:0] now_ms,
                            input logic pinned, input result_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pinned_q.push_back('{pinned, want});
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, now_ms, level};
      do @(posedge clock); while (!req_tready);
      polls_sent++;
   endtask

   // Waits until every poll has been answered, then writes both intervals
   // back to back, the lockout first.
   task automatic write_settings(input logic [15:0] lockout, input logic [15:0] period);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (displays_seen < polls_sent) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= lockout;
      @(posedge clock);
      csr_index <= CSR_INTERVAL;
      csr_wdata <= period;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // A run of button activity under one setting. A finger holds the button
   // down or lets it go now and then, and after each change the contact
   // chatters for a few polls. Time moves forward in steps scaled to the
   // lockout and the period so that both are crossed often; a few polls
   // carry a wholly random time and level as noise.
   task automatic random_phase(input int polls, input logic [15:0] lockout,
                               input logic [15:0] period, input logic [31:0] start_ms);
      logic [31:0] now_ms;
      logic        finger;
      logic        level;
      int          chatter;
      int          step_max;
      write_settings(lockout, period);
      now_ms   = start_ms;
      finger   = 1'b1;
      chatter  = 0;
      step_max = lockout / 4 + period / 8 + 2;
      repeat (polls) begin
         if ($urandom_range(0, 11) == 0) begin
            finger  = ~finger;
            chatter = $urandom_range(0, 4);
         end
         now_ms += $urandom_range(0, step_max);
         if ($urandom_range(0, 19) == 0) begin
            send_poll(1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
         end else begin
            level = (chatter > 0) ? 1'($urandom_range(0, 1)) : finger;
            if (chatter > 0) chatter--;
            send_poll(level, now_ms, 1'b0, '0);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].settings) begin
            write_settings(script[i].lockout, script[i].period);
         end else begin
            send_poll(script[i].level, script[i].now_ms, script[i].pinned, script[i].want);
         end
      end

      // Random phases: both extremes, one start just below the time wrap,
      // and a few random settings.
      random_phase(300, 16'd0, 16'd0, $urandom());
      random_phase(300, 16'hFFFF, 16'hFFFF, $urandom());
      random_phase(300, 16'($urandom_range(0, 120)), 16'($urandom_range(0, 600)),
                   32'hFFFF_FFFF - $urandom_range(0, 3000));
      repeat (3) begin
         random_phase(300, 16'($urandom_range(0, 200)), 16'($urandom_range(0, 900)),
                      $urandom());
      end

      // Drain: every poll must be answered, then a final wait catches any stray
      // response beat.
      req_tvalid <= 1'b0;
      while (displays_seen < polls_sent) @(posedge clock);
      repeat (8) @(posedge clock);
      if (display_q.size() != 0) begin
         $error("%0d predicted displays never arrived", display_q.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/dmlps_pkg.sv
rtl/dmlps_step.sv
rtl/debounced_mode_led_pattern_sequencer.sv
test/tb.sv
